// File: rtl/mcgs_pkg.sv
// Shared types, codes and chain tables for the Gillespie stepper.
package mcgs_pkg;

    localparam int NUM_RATES    = 40;
    localparam int NUM_STATES   = 32;
    localparam int DECODE_LIMIT = 23;
    localparam int DIV_N        = 62;
    localparam int DIV_D        = 35;

    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_SPARE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  rate_index;
        logic [31:0] rate_value;
        logic [4:0]  start_state;
        logic [31:0] r_time;
        logic [31:0] r_pick;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  state_now;
        logic [63:0] dwell_time;
        logic        finished;
        logic [63:0] decode_span;
        logic [63:0] transl_span;
    } t_out_item;

    // exits of a state are contiguous in transition numbering
    localparam logic [5:0] EXIT_START [NUM_STATES] = '{
        6'd0,  6'd4,  6'd5,  6'd7,  6'd9,  6'd10, 6'd11, 6'd0,
        6'd0,  6'd13, 6'd15, 6'd17, 6'd18, 6'd19, 6'd0,  6'd0,
        6'd21, 6'd23, 6'd25, 6'd26, 6'd27, 6'd29, 6'd30, 6'd31,
        6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd0};

    localparam logic [2:0] EXIT_COUNT [NUM_STATES] = '{
        3'd4, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd0,
        3'd0, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd0, 3'd0,
        3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd2,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0};

    localparam logic [4:0] TR_TO [NUM_RATES] = '{
        5'd1,  5'd2,  5'd9,  5'd16, 5'd0,  5'd0,  5'd3,  5'd2,  5'd4,  5'd5,
        5'd6,  5'd0,  5'd21, 5'd0,  5'd10, 5'd9,  5'd11, 5'd12, 5'd13, 5'd0,
        5'd21, 5'd0,  5'd17, 5'd16, 5'd18, 5'd19, 5'd20, 5'd0,  5'd21, 5'd22,
        5'd23, 5'd22, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31};

endpackage

// File: rtl/mcgs_mul.sv
// Shared 32 x 32 unsigned multiplier.
module mcgs_mul
    import mcgs_pkg::*;
(
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    assign o_p = 64'(i_a) * 64'(i_b);

endmodule

// File: rtl/mcgs_div.sv
// Restoring divider, one quotient bit per cycle.
module mcgs_div
    import mcgs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_N-1:0] i_num,
    input  logic [DIV_D-1:0] i_den,
    output logic             o_done,
    output logic [DIV_N-1:0] o_quo
);

    logic [DIV_D-1:0] r_rem;
    logic [DIV_N-1:0] r_quo;
    logic [DIV_D-1:0] r_den;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_D:0]   w_t;
    logic             w_ge;

    assign w_t  = {r_rem, r_quo[DIV_N-1]};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'(DIV_N - 1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? DIV_D'(w_t - {1'b0, r_den}) : w_t[DIV_D-1:0];
                r_quo <= {r_quo[DIV_N-2:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_N - 1))
                    r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done)
        else $error("divider done while busy");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < 6'(DIV_N))
        else $error("divider count overrun");

endmodule

// File: rtl/markov_chain_gillespie_step.sv
// Gillespie direct-method stepper: sequencer, rate memory and time sums.
// Load and set-state transfers are accepted back to back.
// A step stalls the input through the rate sum, the pick, normalisation, the squarings,
// the log scaling, the divide and the control states, plus any output stall.
// A step with no enabled exit stalls through the rate sum and check, then until its finish result can be registered.
// Synchronous reset clears state, time sums and control; rate words are not reset.
module markov_chain_gillespie_step
    import mcgs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SUM_A, S_SUM_D, S_CHK, S_MLO, S_MHI, S_PICK,
        S_NORM, S_SQ, S_LN, S_LN2, S_LN3, S_DIV, S_DONE, S_FIN
    } t_state;

    t_state      r_state;
    logic [31:0] r_mem [NUM_RATES];
    logic [31:0] r_rd;
    logic [4:0]  r_cur;
    logic [4:0]  r_next;
    logic [5:0]  r_start;
    logic [2:0]  r_cnt_ex;
    logic [2:0]  r_k;
    logic [31:0] r_rates [4];
    logic [34:0] r_a0;
    logic [34:0] r_cum;
    logic [66:0] r_thr;
    logic [63:0] r_prod;
    logic [31:0] r_pick;
    logic [31:0] r_y;
    logic [4:0]  r_p;
    logic [31:0] r_f;
    logic [4:0]  r_i;
    logic [37:0] r_neg;
    logic [37:0] r_acc;
    logic [61:0] r_lnv;
    logic        r_div_go;
    logic [63:0] r_total;
    logic [63:0] r_mark;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mp;
    logic        w_div_done;
    logic [61:0] w_quo;
    logic        w_out_free;
    logic        w_acc;
    logic        w_emit;
    logic [32:0] w_sq;
    logic [34:0] w_cum;
    logic [5:0]  w_addr;
    logic [63:0] w_sum;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_emit     = (r_state == S_DONE || r_state == S_FIN) && w_out_free;
    assign w_sq       = w_mp[63:31];
    assign w_cum      = r_cum + 35'(r_rates[r_k[1:0]]);
    assign w_addr     = r_start + 6'(r_k);
    assign w_sum      = r_total + 64'(w_quo);

    always_comb begin
        unique case (r_state)
            S_MLO:   begin w_ma = r_a0[31:0];              w_mb = r_pick;  end
            S_MHI:   begin w_ma = {29'b0, r_a0[34:32]};    w_mb = r_pick;  end
            S_LN2:   begin w_ma = r_neg[31:0];             w_mb = LN2_Q32; end
            S_LN3:   begin w_ma = {26'b0, r_neg[37:32]};   w_mb = LN2_Q32; end
            default: begin w_ma = r_y;                     w_mb = r_y;     end
        endcase
    end

    mcgs_mul u_mul (.i_a(w_ma), .i_b(w_mb), .o_p(w_mp));

    mcgs_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_num  (r_lnv),
        .i_den  (r_a0),
        .o_done (w_div_done),
        .o_quo  (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_acc && i_in_data.cmd == CMD_LOAD
                && i_in_data.rate_index < 6'(NUM_RATES))
            r_mem[i_in_data.rate_index] <= i_in_data.rate_value;
        r_rd <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_total     <= '0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            r_div_go <= (r_state == S_LN3);
            if (w_emit)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (i_in_data.cmd)
                            CMD_SET: r_cur <= i_in_data.start_state;
                            CMD_STEP: begin
                                r_start  <= EXIT_START[r_cur];
                                r_cnt_ex <= EXIT_COUNT[r_cur];
                                r_k      <= '0;
                                r_a0     <= '0;
                                r_pick   <= i_in_data.r_pick;
                                r_y      <= (i_in_data.r_time == 32'd0) ? 32'd1
                                                                        : i_in_data.r_time;
                                r_p      <= 5'd31;
                                r_state  <= (EXIT_COUNT[r_cur] == 3'd0) ? S_CHK : S_SUM_A;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SUM_A: begin
                    r_state <= S_SUM_D;
                end
                S_SUM_D: begin
                    r_rates[r_k[1:0]] <= r_rd;
                    r_a0              <= r_a0 + 35'(r_rd);
                    r_k               <= r_k + 3'd1;
                    r_state           <= (r_k + 3'd1 == r_cnt_ex) ? S_CHK : S_SUM_A;
                end
                S_CHK: begin
                    r_state <= (r_a0 == '0) ? S_FIN : S_MLO;
                end
                S_MLO: begin
                    r_prod  <= w_mp;
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_thr   <= {3'b0, r_prod} + {w_mp[34:0], 32'b0};
                    r_k     <= '0;
                    r_cum   <= '0;
                    r_next  <= r_cur;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (r_k == r_cnt_ex) begin
                        r_state <= S_NORM;
                    end else begin
                        r_k <= r_k + 3'd1;
                        if (r_rates[r_k[1:0]] != 32'd0) begin
                            r_cum  <= w_cum;
                            r_next <= TR_TO[w_addr];
                            if ({w_cum, 32'b0} >= r_thr)
                                r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (r_y[31]) begin
                        r_i     <= '0;
                        r_f     <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_y <= {r_y[30:0], 1'b0};
                        r_p <= r_p - 5'd1;
                    end
                end
                S_SQ: begin
                    r_f <= {r_f[30:0], w_sq[32]};
                    r_y <= w_sq[32] ? w_sq[32:1] : w_sq[31:0];
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'd31)
                        r_state <= S_LN;
                end
                S_LN: begin
                    r_neg   <= {6'(6'd32 - 6'(r_p)), 32'b0} - 38'(r_f);
                    r_state <= S_LN2;
                end
                S_LN2: begin
                    r_acc   <= 38'(w_mp[63:32]);
                    r_state <= S_LN3;
                end
                S_LN3: begin
                    r_lnv    <= {38'(w_mp[37:0] + r_acc), 24'b0};
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done)
                        r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_cur <= r_next;
                        if (r_next < 5'(DECODE_LIMIT))
                            r_mark <= r_total;
                        r_total <= (w_sum < r_total) ? '1 : w_sum;
                        r_out.state_now   <= r_next;
                        r_out.dwell_time  <= 64'(w_quo);
                        r_out.finished    <= 1'b0;
                        r_out.decode_span <= '0;
                        r_out.transl_span <= '0;
                        r_state           <= S_IDLE;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out.state_now   <= r_cur;
                        r_out.dwell_time  <= '0;
                        r_out.finished    <= 1'b1;
                        r_out.decode_span <= r_mark;
                        r_out.transl_span <= (r_total >= r_mark) ? r_total - r_mark : '0;
                        r_total           <= '0;
                        r_mark            <= '0;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_data.cmd == CMD_STEP) |=> o_in_stall)
        else $error("step accepted but block not busy");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_a0 != '0))
        else $error("division by zero rate sum");

    a_fin_dwell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.finished) |-> (o_out_data.dwell_time == '0))
        else $error("finished result with dwell");

endmodule

// File: sim/gillespie_checker.sv
// Checker: predicts Gillespie step results from observed transfers and compares them.
`timescale 1ns / 100ps
module gillespie_checker
    import mcgs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam logic [5:0] TR_FROM [NUM_RATES] = '{
        6'd0, 6'd0, 6'd0, 6'd0, 6'd1, 6'd2, 6'd2, 6'd3, 6'd3, 6'd4,
        6'd5, 6'd6, 6'd6, 6'd9, 6'd9, 6'd10, 6'd10, 6'd11, 6'd12, 6'd13,
        6'd13, 6'd16, 6'd16, 6'd17, 6'd17, 6'd18, 6'd19, 6'd20, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30};

    logic [4:0]  cur_state;
    logic [31:0] rates [NUM_RATES];
    logic [63:0] time_sum;
    logic [63:0] mark_time;
    t_out_item   step_queue[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = step_queue.size();

    function automatic logic [63:0] neg_ln(input logic [31:0] r);
        int          msb;
        logic [63:0] y, f, n, nl;
        logic [127:0] sq;
        msb = 0;
        f = 0;
        for (int b = 0; b < 32; b++) if (r[b]) msb = b;
        y = 64'(r) << (31 - msb);
        for (int i = 0; i < 32; i++) begin
            sq = 128'(y) * 128'(y);
            y = 64'(sq >> 31);
            f = f << 1;
            if (y >= 64'h1_0000_0000) begin
                y = y >> 1;
                f[0] = 1'b1;
            end
        end
        n = (64'(32 - msb) << 32) - f;
        nl = {32'd0, n[31:0]};
        return n[63:32] * 64'(LN2_Q32) + ((nl * 64'(LN2_Q32)) >> 32);
    endfunction

    task automatic predict_step(input t_in_item it);
        t_out_item   res;
        logic [63:0] a0, cum, thr_hi, thr_lo, al, lnv, dwell, sum;
        logic [127:0] num;
        logic [31:0] rt;
        logic [4:0]  nxt;
        a0 = 0;
        cum = 0;
        nxt = cur_state;
        res = '0;
        for (int i = 0; i < NUM_RATES; i++)
            if (TR_FROM[i] == cur_state && rates[i] != 0) a0 += rates[i];
        if (a0 == 0) begin
            res.state_now = cur_state;
            res.finished = 1'b1;
            res.decode_span = mark_time;
            res.transl_span = (time_sum >= mark_time) ? time_sum - mark_time : 0;
            time_sum = 0;
            mark_time = 0;
        end else begin
            al = {32'd0, a0[31:0]} * {32'd0, it.r_pick};
            thr_hi = (a0 >> 32) * {32'd0, it.r_pick} + (al >> 32);
            thr_lo = {32'd0, al[31:0]};
            for (int i = 0; i < NUM_RATES; i++) begin
                if (TR_FROM[i] == cur_state && rates[i] != 0) begin
                    cum += rates[i];
                    nxt = TR_TO[i];
                    if (cum > thr_hi || (cum == thr_hi && thr_lo == 0)) break;
                end
            end
            rt = (it.r_time == 0) ? 32'd1 : it.r_time;
            lnv = neg_ln(rt);
            num = 128'(lnv) << 24;
            dwell = 64'(num / 128'(a0));
            cur_state = nxt;
            if (cur_state < DECODE_LIMIT) mark_time = time_sum;
            sum = time_sum + dwell;
            time_sum = (sum < time_sum) ? '1 : sum;
            res.state_now = cur_state;
            res.dwell_time = dwell;
        end
        step_queue = {step_queue, res};
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_state = '0;
            time_sum = '0;
            mark_time = '0;
            fails <= 0;
            for (int i = 0; i < NUM_RATES; i++) rates[i] = '0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                case (t_cmd'(i_in_data.cmd))
                    CMD_LOAD:  if (i_in_data.rate_index < NUM_RATES)
                                   rates[i_in_data.rate_index] = i_in_data.rate_value;
                    CMD_SET:   cur_state = i_in_data.start_state;
                    CMD_STEP:  predict_step(i_in_data);
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (step_queue.size() == 0) begin
                    $error("unexpected result transfer");
                    fails <= fails + 1;
                end else begin
                    t_out_item e;
                    int bad;
                    e = step_queue.pop_front();
                    bad = 0;
                    if (e.state_now !== i_out_data.state_now) begin
                        $error("state_now exp %0d got %0d", e.state_now, i_out_data.state_now);
                        bad++;
                    end
                    if (e.dwell_time !== i_out_data.dwell_time) begin
                        $error("dwell_time exp %h got %h", e.dwell_time, i_out_data.dwell_time);
                        bad++;
                    end
                    if (e.finished !== i_out_data.finished) begin
                        $error("finished exp %0d got %0d", e.finished, i_out_data.finished);
                        bad++;
                    end
                    if (e.decode_span !== i_out_data.decode_span) begin
                        $error("decode_span exp %h got %h", e.decode_span,
                               i_out_data.decode_span);
                        bad++;
                    end
                    if (e.transl_span !== i_out_data.transl_span) begin
                        $error("transl_span exp %h got %h", e.transl_span,
                               i_out_data.transl_span);
                        bad++;
                    end
                    fails <= fails + bad;
                end
            end
        end
    end

endmodule

// File: sim/testbench.sv
// Stimulus and verdict for the Gillespie stepper.
`timescale 1ns / 100ps
module testbench;
    import mcgs_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;
    int        fail_count, pending;
    int        cycles = 0;
    bit        hold_long = 1'b0;

    localparam int CYCLE_LIMIT = 1500000;

    always #6 clk = ~clk;

    markov_chain_gillespie_step dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_in_data(in_data), .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_data(out_data));

    gillespie_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_in_data(in_data), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_data(out_data), .o_fail_count(fail_count), .o_pending(pending));

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stall pattern; long hold-off on request
    initial begin
        int n;
        bit held;
        held = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_long && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
            end
            n = $urandom_range(0, 3);
            out_stall <= (n == 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    int burst_left = 0;

    task automatic send(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    function automatic t_in_item mk(input t_cmd c, input logic [5:0] idx,
                                    input logic [31:0] rv, input logic [4:0] st,
                                    input logic [31:0] rt, input logic [31:0] rp);
        t_in_item it;
        it.cmd = c; it.rate_index = idx; it.rate_value = rv;
        it.start_state = st; it.r_time = rt; it.r_pick = rp;
        return it;
    endfunction

    function automatic t_in_item rnd_item(input t_cmd c);
        t_in_item it;
        it.cmd = c;
        it.rate_index = 6'($urandom_range(0, NUM_RATES - 1));
        it.rate_value = $urandom;
        it.start_state = 5'($urandom);
        it.r_time = $urandom;
        it.r_pick = $urandom;
        return it;
    endfunction

    task automatic idle_wait();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial begin
        t_in_item it;
        int k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // every rate word written before any step
        for (int i = 0; i < NUM_RATES; i++)
            send(mk(CMD_LOAD, 6'(i), (i % 3 == 0) ? 32'hFFFFFFFF : 32'd256 + i, 0, 0, 0));
        send(mk(CMD_STEP, 0, 0, 0, 32'd0, 32'd0));
        send(mk(CMD_STEP, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send(mk(CMD_SET, 0, 0, 5'd31, 0, 0));
        send(mk(CMD_STEP, 0, 0, 0, 32'h8000_0000, 32'h1234));
        send(mk(CMD_SPARE, 6'h3F, 32'hFFFFFFFF, 5'h1F, 32'hFFFFFFFF, 32'hFFFFFFFF));
        send(mk(CMD_LOAD, 6'd63, 32'hFFFFFFFF, 0, 0, 0));
        send(mk(CMD_LOAD, 6'd2, 32'd0, 0, 0, 0));
        send(mk(CMD_SET, 0, 0, 5'd22, 0, 0));
        send(mk(CMD_STEP, 0, 0, 0, 32'd1, 32'h8000_0000));
        send(mk(CMD_STEP, 0, 0, 0, 32'd2, 32'hFFFFFFFF));
        send(mk(CMD_LOAD, 6'd1, 32'd1, 0, 0, 0));
        send(mk(CMD_SET, 0, 0, 5'd0, 0, 0));
        send(mk(CMD_STEP, 0, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        idle_wait();
        // long receiver hold-off while sender keeps offering steps
        hold_long = 1'b1;
        for (int i = 0; i < 12; i++) send(rnd_item(CMD_STEP));
        idle_wait();
        k = 0;
        while (k < 700) begin
            case ($urandom_range(0, 19))
                0, 1, 2:  it = rnd_item(CMD_LOAD);
                3:        it = rnd_item(CMD_SET);
                4:        it = rnd_item(CMD_SPARE);
                5: begin
                    it = rnd_item(CMD_LOAD);
                    it.rate_value = ($urandom_range(0, 1)) ? 32'd0 : 32'hFFFFFFFF;
                    it.rate_index = 6'($urandom);
                end
                default:  it = rnd_item(CMD_STEP);
            endcase
            if ($urandom_range(0, 15) == 0) it.r_time = 0;
            if ($urandom_range(0, 15) == 0) it.r_pick = 0;
            send(it);
            k++;
            if (k == 350) idle_wait();
        end
        idle_wait();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mcgs_pkg.sv
rtl/mcgs_mul.sv
rtl/mcgs_div.sv
rtl/markov_chain_gillespie_step.sv
sim/gillespie_checker.sv
sim/testbench.sv
